### design/gbn_pkg.sv
package gbn_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int MAX_RESEND    = 64;
    localparam int PSUM_W        = 13;

    typedef enum logic [1:0] {
        CMD_MSG  = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TMO  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        TIMER_NONE  = 2'd0,
        TIMER_START = 2'd1,
        TIMER_STOP  = 2'd2
    } timer_t;

    // controller to datapath
    typedef struct packed {
        logic   in_ready;
        logic   mod_a;
        logic   mod_b;
        logic   mod_tail;
        logic   ram_we;
        logic   ram_re;
        logic   sum_in;
        logic   sum_ram;
        logic   tail_inc;
        logic   seq_load_next;
        logic   seq_load_base;
        logic   cnt_load;
        logic   emit;
        logic   e_pkt;
        logic   e_dropped;
        logic   e_ack;
        timer_t timer;
        logic   last;
        logic   next_inc;
        logic   seq_step;
    } gbn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_fire;
        cmd_t cmd;
        logic full;
        logic win_open;
        logic n_pos;
        logic eq_bn;
        logic first;
        logic cnt_last;
        logic out_free;
    } gbn_stat_t;

    // sum of the payload bytes, each read as a signed byte, as an adder tree
    function automatic logic signed [PSUM_W-1:0] sbyte_sum(input logic [PAYLOAD_W-1:0] p);
        logic signed [PSUM_W-1:0] t [PAYLOAD_BYTES];
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            t[i] = signed'({{(PSUM_W-8){p[8*i+7]}}, p[8*i +: 8]});
        end
        for (int w = 1; w < PAYLOAD_BYTES; w = w * 2)
        begin
            for (int i = 0; i + w < PAYLOAD_BYTES; i = i + 2 * w)
            begin
                t[i] = t[i] + t[i + w];
            end
        end
        return t[0];
    endfunction

endpackage

### design/gbn_if.sv
interface gbn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [63:0]        payload_low;
    logic [63:0]        payload_mid;
    logic [31:0]        payload_high;
    logic [15:0]        pkt_seq;
    logic signed [16:0] pkt_ack;
    logic signed [31:0] pkt_checksum;

    modport source (output valid, cmd, payload_low, payload_mid, payload_high, pkt_seq,
                    pkt_ack, pkt_checksum, input ready);
    modport sink (input valid, cmd, payload_low, payload_mid, payload_high, pkt_seq,
                  pkt_ack, pkt_checksum, output ready);
endinterface

interface gbn_out_if;
    logic               valid;
    logic               ready;
    logic               send_valid;
    logic [15:0]        send_seq;
    logic signed [17:0] send_checksum;
    logic [63:0]        out_low;
    logic [63:0]        out_mid;
    logic [31:0]        out_high;
    logic [1:0]         timer_cmd;
    logic               dropped;
    logic               last;

    modport source (output valid, send_valid, send_seq, send_checksum, out_low, out_mid,
                    out_high, timer_cmd, dropped, last, input ready);
    modport sink (input valid, send_valid, send_seq, send_checksum, out_low, out_mid,
                  out_high, timer_cmd, dropped, last, output ready);
endinterface

interface gbn_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### design/go_back_n_sender.sv
// Go-Back-N sender. Messages are kept in a ring of BUFFER_DEPTH payloads and
// sent while the window (cfg, reset 8) is open; acks move the window base and
// timeouts resend the outstanding packets, up to 64 results for one timeout.
// One item is handled at a time. Each sent or resent packet passes through the
// slot unit (a reciprocal multiply then a multiply-subtract for the ring
// index), the ring's single registered read port and a checksum step before
// its result is emitted, and any result waits while the output register is
// full. A result waiting at the output does not stop the next item from
// being taken.
module go_back_n_sender
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    gbn_in_if.sink    item_in,
    gbn_out_if.source result_out,
    gbn_cfg_if.sink   cfg
);
    gbn_cmd_t  ctl;
    gbn_stat_t stat;

    gbn_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .ctl  (ctl)
    );

    gbn_dp #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .result_out(result_out),
        .cfg       (cfg),
        .ctl       (ctl),
        .stat      (stat)
    );
endmodule

### design/gbn_ram.sv
module gbn_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/gbn_ctrl.sv
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gbn_stat_t stat,
    output gbn_cmd_t  ctl
);
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_W_MA   = 14'b00000000000100,
        S_W_MB   = 14'b00000000001000,
        S_W_WR   = 14'b00000000010000,
        S_S_MA   = 14'b00000000100000,
        S_S_MB   = 14'b00000001000000,
        S_S_RD   = 14'b00000010000000,
        S_S_SUM  = 14'b00000100000000,
        S_E_PKT  = 14'b00001000000000,
        S_E_ZERO = 14'b00010000000000,
        S_E_DROP = 14'b00100000000000,
        S_E_TMO  = 14'b01000000000000,
        S_E_ACK  = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (stat.in_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_MSG:  state_next = stat.full ? S_E_DROP : S_W_MA;
                    CMD_ACK:
                    begin
                        ctl.sum_in = 1'b1;
                        state_next = S_E_ACK;
                    end
                    CMD_TMO:
                    begin
                        if (stat.n_pos)
                        begin
                            ctl.cnt_load      = 1'b1;
                            ctl.seq_load_base = 1'b1;
                            state_next        = S_S_MA;
                        end
                        else
                        begin
                            state_next = S_E_TMO;
                        end
                    end
                    CMD_NONE: state_next = S_E_ZERO;
                endcase
            end
            S_W_MA:
            begin
                ctl.mod_a    = 1'b1;
                ctl.mod_tail = 1'b1;
                state_next   = S_W_MB;
            end
            S_W_MB:
            begin
                ctl.mod_b    = 1'b1;
                ctl.mod_tail = 1'b1;
                state_next   = S_W_WR;
            end
            S_W_WR:
            begin
                ctl.ram_we        = 1'b1;
                ctl.tail_inc      = 1'b1;
                ctl.seq_load_next = 1'b1;
                state_next        = stat.win_open ? S_S_MA : S_E_ZERO;
            end
            S_S_MA:
            begin
                ctl.mod_a  = 1'b1;
                state_next = S_S_MB;
            end
            S_S_MB:
            begin
                ctl.mod_b  = 1'b1;
                state_next = S_S_RD;
            end
            S_S_RD:
            begin
                ctl.ram_re = 1'b1;
                state_next = S_S_SUM;
            end
            S_S_SUM:
            begin
                ctl.sum_ram = 1'b1;
                state_next  = S_E_PKT;
            end
            S_E_PKT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit  = 1'b1;
                    ctl.e_pkt = 1'b1;
                    if (stat.cmd == CMD_MSG)
                    begin
                        ctl.timer    = stat.eq_bn ? TIMER_START : TIMER_NONE;
                        ctl.last     = 1'b1;
                        ctl.next_inc = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        ctl.timer    = stat.first ? TIMER_START : TIMER_NONE;
                        ctl.last     = stat.cnt_last;
                        ctl.seq_step = 1'b1;
                        state_next   = stat.cnt_last ? S_IDLE : S_S_MA;
                    end
                end
            end
            S_E_ZERO, S_E_DROP, S_E_TMO, S_E_ACK:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.last      = 1'b1;
                    ctl.e_dropped = (state_reg == S_E_DROP);
                    ctl.e_ack     = (state_reg == S_E_ACK);
                    ctl.timer     = (state_reg == S_E_TMO) ? TIMER_START : TIMER_NONE;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // input is taken only in idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");

    // an accepted item is always decoded next
    a_fire_decode: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_fire && ctl.in_ready |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");

    // a ring read is always followed by the checksum step
    a_read_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ram_re |=> ctl.sum_ram)
        else $error("read data not summed");
`endif
endmodule

### design/gbn_dp.sv
module gbn_dp
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    gbn_in_if.sink    item_in,
    gbn_out_if.source result_out,
    gbn_cfg_if.sink   cfg,
    input  gbn_cmd_t  ctl,
    output gbn_stat_t stat
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam longint unsigned MREC_L = ((64'd1 << 32) + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
    localparam logic [31:0] MREC = MREC_L[31:0];
    localparam logic [16:0] DEPTH_U = 17'(BUFFER_DEPTH);
    localparam logic signed [16:0] DEPTH_S = 17'(BUFFER_DEPTH);

    logic [5:0]               wsize_reg;
    cmd_t                     cmd_reg;
    logic [PAYLOAD_W-1:0]     pay_reg;
    logic [15:0]              pkt_seq_reg;
    logic signed [16:0]       pkt_ack_reg;
    logic signed [31:0]       pkt_cs_reg;
    logic [15:0]              base_reg;
    logic [15:0]              next_reg;
    logic [15:0]              tail_reg;
    logic [15:0]              seq_reg;
    logic [6:0]               cnt_reg;
    logic [15:0]              q_reg;
    logic [AW-1:0]            slot_reg;
    logic signed [PSUM_W-1:0] psum_reg;
    logic [PAYLOAD_W-1:0]     rdata;

    logic                     out_valid_reg;
    logic                     o_send_reg;
    logic [15:0]              o_seq_reg;
    logic signed [17:0]       o_cs_reg;
    logic [PAYLOAD_W-1:0]     o_pay_reg;
    timer_t                   o_timer_reg;
    logic                     o_drop_reg;
    logic                     o_last_reg;

    logic signed [15:0] d_tb;
    logic signed [15:0] d_nb;
    logic [15:0]        mod_x;
    logic [47:0]        prod;
    logic [16:0]        rem;
    logic [15:0]        ack_next;
    logic signed [31:0] ack_sum;
    logic               cs_ok;
    timer_t             timer_sel;
    logic               in_fire;

    assign in_fire      = item_in.valid && ctl.in_ready;
    assign item_in.ready = ctl.in_ready;
    assign cfg.ready    = 1'b1;

    // distances and window tests
    assign d_tb = signed'(tail_reg - base_reg);
    assign d_nb = signed'(next_reg - base_reg);

    assign stat.in_fire  = in_fire;
    assign stat.cmd      = cmd_reg;
    assign stat.full     = signed'({d_tb[15], d_tb}) >= DEPTH_S;
    assign stat.win_open = signed'({d_nb[15], d_nb}) < signed'({11'b0, wsize_reg});
    assign stat.n_pos    = d_nb > 16'sd0;
    assign stat.eq_bn    = base_reg == next_reg;
    assign stat.first    = seq_reg == base_reg;
    assign stat.cnt_last = cnt_reg == 7'd1;
    assign stat.out_free = !out_valid_reg || result_out.ready;

    // slot = value mod depth by reciprocal multiply
    assign mod_x = ctl.mod_tail ? tail_reg : seq_reg;
    assign prod  = 48'(mod_x) * 48'(MREC);
    assign rem   = 17'(mod_x) - 17'(q_reg) * DEPTH_U;

    // ack checksum check
    assign ack_sum  = {{(32-PSUM_W){psum_reg[PSUM_W-1]}}, psum_reg}
                    + {{15{pkt_ack_reg[16]}}, pkt_ack_reg}
                    + {16'b0, pkt_seq_reg};
    assign cs_ok    = ack_sum == pkt_cs_reg;
    assign ack_next = pkt_ack_reg[15:0] + 16'd1;

    always_comb
    begin
        timer_sel = ctl.timer;
        if (ctl.e_ack)
        begin
            timer_sel = !cs_ok ? TIMER_NONE
                      : ((ack_next == next_reg) ? TIMER_STOP : TIMER_START);
        end
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg <= 6'd8;
        end
        else if (cfg.valid)
        begin
            wsize_reg <= cfg.data;
        end
    end

    // window counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            next_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (ctl.tail_inc)
            begin
                tail_reg <= tail_reg + 16'd1;
            end
            if (ctl.emit && ctl.next_inc)
            begin
                next_reg <= next_reg + 16'd1;
            end
            if (ctl.emit && ctl.e_ack && cs_ok)
            begin
                base_reg <= ack_next;
            end
        end
    end

    // item capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_NONE;
        end
        else if (in_fire)
        begin
            cmd_reg <= cmd_t'(item_in.cmd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pay_reg     <= {item_in.payload_high, item_in.payload_mid, item_in.payload_low};
            pkt_seq_reg <= item_in.pkt_seq;
            pkt_ack_reg <= item_in.pkt_ack;
            pkt_cs_reg  <= item_in.pkt_checksum;
        end
    end

    // resend walk and slot unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_load)
        begin
            cnt_reg <= (d_nb > 16'sd64) ? 7'(MAX_RESEND) : d_nb[6:0];
        end
        else if (ctl.emit && ctl.seq_step)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.seq_load_base)
        begin
            seq_reg <= base_reg;
        end
        else if (ctl.seq_load_next)
        begin
            seq_reg <= next_reg;
        end
        else if (ctl.emit && ctl.seq_step)
        begin
            seq_reg <= seq_reg + 16'd1;
        end
        if (ctl.mod_a)
        begin
            q_reg <= prod[47:32];
        end
        if (ctl.mod_b)
        begin
            slot_reg <= rem[AW-1:0];
        end
        if (ctl.sum_in || ctl.sum_ram)
        begin
            psum_reg <= sbyte_sum(ctl.sum_in ? pay_reg : rdata);
        end
    end

    // payload ring
    gbn_ram #(
        .WIDTH(PAYLOAD_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ctl.ram_we),
        .waddr(slot_reg),
        .wdata(pay_reg),
        .re   (ctl.ram_re),
        .raddr(slot_reg),
        .rdata(rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            o_send_reg  <= ctl.e_pkt;
            o_seq_reg   <= ctl.e_pkt ? seq_reg : '0;
            o_cs_reg    <= ctl.e_pkt ? ({{(18-PSUM_W){psum_reg[PSUM_W-1]}}, psum_reg}
                                        + {2'b0, seq_reg}) : '0;
            o_pay_reg   <= ctl.e_pkt ? rdata : '0;
            o_timer_reg <= timer_sel;
            o_drop_reg  <= ctl.e_dropped;
            o_last_reg  <= ctl.last;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.send_valid    = o_send_reg;
    assign result_out.send_seq      = o_seq_reg;
    assign result_out.send_checksum = o_cs_reg;
    assign result_out.out_low       = o_pay_reg[63:0];
    assign result_out.out_mid       = o_pay_reg[127:64];
    assign result_out.out_high      = o_pay_reg[159:128];
    assign result_out.timer_cmd     = o_timer_reg;
    assign result_out.dropped       = o_drop_reg;
    assign result_out.last          = o_last_reg;

`ifndef NO_ASSERTIONS
    // resend count stays within the result limit
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(MAX_RESEND))
        else $error("resend count out of range");

    // only messages write the ring
    a_we_msg: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ram_we |-> cmd_reg == CMD_MSG)
        else $error("ring write outside message");

    // a result is loaded only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> stat.out_free)
        else $error("result overwritten");
`endif
endmodule
